### rtl/mce_pkg.sv
// shared types, constants and the character code table of the morse encoder
package mce_pkg;

    // timing in units
    localparam logic [2:0] WordGapUnits = 3'd7;
    localparam logic [2:0] CharGapUnits = 3'd3;
    localparam logic [2:0] DashUnits    = 3'd3;
    localparam logic [2:0] DotUnits     = 3'd1;
    localparam logic [2:0] SymGapUnits  = 3'd1;

    // character bytes
    localparam logic [7:0] CharSpace     = 8'h20;
    localparam logic [7:0] CharUpperA    = 8'h41;
    localparam logic [7:0] CharUpperZ    = 8'h5A;
    localparam logic [7:0] CharLowerA    = 8'h61;
    localparam logic [7:0] CharLowerZ    = 8'h7A;
    localparam logic [7:0] CharDigit0    = 8'h30;
    localparam logic [7:0] CharDigit9    = 8'h39;
    localparam logic [7:0] FoldOffset    = CharLowerA - CharUpperA;

    // code word: symbol count and dash mask, bit 0 is the first symbol
    typedef struct packed {
        logic [2:0] len;
        logic [4:0] pat;
    } t_mce_code;

    localparam t_mce_code LetterTable [26] = '{
        '{3'd2, 5'b00010},  // A
        '{3'd4, 5'b00001},  // B
        '{3'd4, 5'b00101},  // C
        '{3'd3, 5'b00001},  // D
        '{3'd1, 5'b00000},  // E
        '{3'd4, 5'b00100},  // F
        '{3'd3, 5'b00011},  // G
        '{3'd4, 5'b00000},  // H
        '{3'd2, 5'b00000},  // I
        '{3'd4, 5'b01110},  // J
        '{3'd3, 5'b00101},  // K
        '{3'd4, 5'b00010},  // L
        '{3'd2, 5'b00011},  // M
        '{3'd2, 5'b00001},  // N
        '{3'd3, 5'b00111},  // O
        '{3'd4, 5'b00110},  // P
        '{3'd4, 5'b01011},  // Q
        '{3'd3, 5'b00010},  // R
        '{3'd3, 5'b00000},  // S
        '{3'd1, 5'b00001},  // T
        '{3'd3, 5'b00100},  // U
        '{3'd4, 5'b01000},  // V
        '{3'd3, 5'b00110},  // W
        '{3'd4, 5'b01001},  // X
        '{3'd4, 5'b01101},  // Y
        '{3'd4, 5'b00011}   // Z
    };

    localparam t_mce_code DigitTable [10] = '{
        '{3'd5, 5'b11111},  // 0
        '{3'd5, 5'b11110},  // 1
        '{3'd5, 5'b11100},  // 2
        '{3'd5, 5'b11000},  // 3
        '{3'd5, 5'b10000},  // 4
        '{3'd5, 5'b00000},  // 5
        '{3'd5, 5'b00001},  // 6
        '{3'd5, 5'b00011},  // 7
        '{3'd5, 5'b00111},  // 8
        '{3'd5, 5'b01111}   // 9
    };

    // run counter reload chosen by the controller
    typedef enum logic [1:0] {
        LD_NONE,
        LD_SYM,
        LD_GAP,
        LD_TRAIL
    } t_mce_ld;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    emit;
        logic    unit_on;
        t_mce_ld ld;
    } t_mce_cmd;

    // datapath to controller
    typedef struct packed {
        logic acc_any;
        logic acc_pre;
        logic acc_code;
        logic cnt_last;
        logic sym_more;
        logic trail;
        logic remain_one;
        logic remain_zero;
    } t_mce_sts;

    // fold case and look up the code word, len of zero means unmapped
    function automatic t_mce_code mce_lookup(input logic [7:0] ch);
        logic [7:0] up;
        t_mce_code  code;
        up   = ch;
        code = '{3'd0, 5'b00000};
        if (ch >= CharLowerA && ch <= CharLowerZ) begin
            up = ch - FoldOffset;
        end
        if (up >= CharUpperA && up <= CharUpperZ) begin
            code = LetterTable[5'(up - CharUpperA)];
        end else if (up >= CharDigit0 && up <= CharDigit9) begin
            code = DigitTable[4'(up - CharDigit0)];
        end
        return code;
    endfunction

endpackage

### rtl/mce_dp.sv
// datapath: decode, word flags, run and unit counters, output payload
module mce_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_char_code,
    input  logic              i_end_of_message,
    input  mce_pkg::t_mce_cmd i_cmd,
    output mce_pkg::t_mce_sts o_sts,
    output logic              o_unit_on,
    output logic              o_last_unit
);

    mce_pkg::t_mce_code w_code;
    logic               w_is_space;
    logic               w_is_code;
    logic [2:0]         w_pre;
    logic [2:0]         w_pop;
    logic [4:0]         w_code_units;
    logic               w_trail;
    logic [5:0]         w_total;
    logic [2:0]         w_first_cnt;

    logic       r_has_char, r_gap_pending, r_written;
    logic [2:0] r_cnt;
    logic [4:0] r_pat;
    logic [2:0] r_sym_left;
    logic       r_trail;
    logic [5:0] r_remain;
    logic       r_unit_on, r_last_unit;

    // decode the offered item
    always_comb begin
        w_code     = mce_pkg::mce_lookup(i_char_code);
        w_is_space = (i_char_code == mce_pkg::CharSpace);
        w_is_code  = (w_code.len != 3'd0);
        w_pop      = 3'd0;
        for (int k = 0; k < 5; k++) begin
            w_pop = w_pop + {2'b00, w_code.pat[k]};
        end
        w_code_units = {1'b0, w_code.len, 1'b0} - 5'd1 + {1'b0, w_pop, 1'b0};
        if (!w_is_code) begin
            w_pre = 3'd0;
        end else if (r_gap_pending) begin
            w_pre = mce_pkg::WordGapUnits;
        end else if (r_has_char) begin
            w_pre = mce_pkg::CharGapUnits;
        end else begin
            w_pre = 3'd0;
        end
        w_trail = i_end_of_message && (r_written || w_is_code);
        w_total = {3'b000, w_pre}
                + (w_is_code ? {1'b0, w_code_units} : 6'd0)
                + (w_trail ? {3'b000, mce_pkg::WordGapUnits} : 6'd0);
        if (w_pre != 3'd0) begin
            w_first_cnt = w_pre;
        end else if (w_is_code) begin
            w_first_cnt = w_code.pat[0] ? mce_pkg::DashUnits : mce_pkg::DotUnits;
        end else begin
            w_first_cnt = mce_pkg::WordGapUnits;
        end
    end

    // status for the controller
    always_comb begin
        o_sts.acc_any     = (w_total != 6'd0);
        o_sts.acc_pre     = (w_pre != 3'd0);
        o_sts.acc_code    = w_is_code;
        o_sts.cnt_last    = (r_cnt == 3'd1);
        o_sts.sym_more    = (r_sym_left > 3'd1);
        o_sts.trail       = r_trail;
        o_sts.remain_one  = (r_remain == 6'd1);
        o_sts.remain_zero = (r_remain == 6'd0);
    end

    // word flags and unit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_char    <= 1'b0;
            r_gap_pending <= 1'b0;
            r_written     <= 1'b0;
            r_remain      <= 6'd0;
        end else if (i_cmd.accept) begin
            r_remain <= w_total;
            if (i_end_of_message) begin
                r_has_char    <= 1'b0;
                r_gap_pending <= 1'b0;
                r_written     <= 1'b0;
            end else if (w_is_space && r_has_char) begin
                r_gap_pending <= 1'b1;
                r_has_char    <= 1'b0;
            end else if (w_is_code) begin
                r_gap_pending <= 1'b0;
                r_has_char    <= 1'b1;
                r_written     <= 1'b1;
            end
        end else if (i_cmd.emit) begin
            r_remain <= r_remain - 6'd1;
        end
    end

    // run counter, symbol shifter and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cnt      <= w_first_cnt;
            r_pat      <= w_code.pat;
            r_sym_left <= w_code.len;
            r_trail    <= w_trail;
        end else if (i_cmd.emit) begin
            r_unit_on   <= i_cmd.unit_on;
            r_last_unit <= (r_remain == 6'd1);
            case (i_cmd.ld)
                mce_pkg::LD_NONE: begin
                    r_cnt <= r_cnt - 3'd1;
                end
                mce_pkg::LD_SYM: begin
                    r_cnt <= r_pat[0] ? mce_pkg::DashUnits : mce_pkg::DotUnits;
                end
                mce_pkg::LD_GAP: begin
                    r_cnt      <= mce_pkg::SymGapUnits;
                    r_pat      <= {1'b0, r_pat[4:1]};
                    r_sym_left <= r_sym_left - 3'd1;
                end
                mce_pkg::LD_TRAIL: begin
                    r_cnt <= mce_pkg::WordGapUnits;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    assign o_unit_on   = r_unit_on;
    assign o_last_unit = r_last_unit;

endmodule

### rtl/mce_ctrl.sv
// controller: phase sequencing of one item and output valid
module mce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall,
    input  mce_pkg::t_mce_sts i_sts,
    output logic              o_stall,
    output logic              o_valid,
    output mce_pkg::t_mce_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_SYM_ON,
        S_SYM_GAP,
        S_TRAIL
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   w_out_free;

    // commands and next state
    always_comb begin
        w_out_free    = !r_valid || !i_stall;
        o_cmd.accept  = i_valid && (r_state == S_IDLE);
        o_cmd.emit    = (r_state != S_IDLE) && w_out_free;
        o_cmd.unit_on = (r_state == S_SYM_ON);
        o_cmd.ld      = mce_pkg::LD_NONE;
        n_state       = r_state;
        n_valid       = o_cmd.emit ? 1'b1 : (r_valid && i_stall);
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_sts.acc_any) begin
                    if (i_sts.acc_pre) begin
                        n_state = S_PRE;
                    end else if (i_sts.acc_code) begin
                        n_state = S_SYM_ON;
                    end else begin
                        n_state = S_TRAIL;
                    end
                end
            end
            S_PRE: begin
                if (o_cmd.emit && i_sts.cnt_last) begin
                    o_cmd.ld = mce_pkg::LD_SYM;
                    n_state  = S_SYM_ON;
                end
            end
            S_SYM_ON: begin
                if (o_cmd.emit && i_sts.cnt_last) begin
                    if (i_sts.sym_more) begin
                        o_cmd.ld = mce_pkg::LD_GAP;
                        n_state  = S_SYM_GAP;
                    end else if (i_sts.trail) begin
                        o_cmd.ld = mce_pkg::LD_TRAIL;
                        n_state  = S_TRAIL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SYM_GAP: begin
                if (o_cmd.emit && i_sts.cnt_last) begin
                    o_cmd.ld = mce_pkg::LD_SYM;
                    n_state  = S_SYM_ON;
                end
            end
            S_TRAIL: begin
                if (o_cmd.emit && i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // no units are owed while idle
    a_idle_no_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> i_sts.remain_zero)
        else $error("units still owed while idle");

    // the final unit ends the item
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.remain_one) |=> (r_state == S_IDLE))
        else $error("sequencer busy after the final unit");

    // an item with units starts a phase
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.acc_any) |=> (r_state != S_IDLE))
        else $error("item with units did not start");

    // a leading gap is always followed by a character
    a_pre_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRE) |-> !i_sts.remain_one)
        else $error("leading gap counted as final unit");

endmodule

### rtl/morse_code_unit_encoder_unit.sv
// top level of the morse code unit encoder
// Each accepted item (one character byte and an end-of-message flag) is turned
// into a train of time units, one unit per result item: a dot is 1 on unit, a
// dash 3 on units, with 1 off unit between symbols, 3 between characters and
// 7 between words; a space arms the word gap, and the end flag adds 7 trailing
// off units when anything was keyed, then clears the word state. Lower case is
// folded to upper case; bytes other than letters, digits and space give no
// units. The block works on one item at a time: an item occupies the
// sequencer from its accept cycle until its last unit (0 to 33 units), as
// the run counter steps one unit per cycle while the output register is free;
// the next item is taken the cycle after the last unit has been registered,
// and an item that yields no units leaves the sequencer idle. Downstream stall
// holds the output register and pauses the sequencer.
module morse_code_unit_encoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_message,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_unit_on,
    output logic       o_last_unit
);

    mce_pkg::t_mce_cmd w_cmd;
    mce_pkg::t_mce_sts w_sts;

    // phase sequencer
    mce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    // decode, counters and output payload
    mce_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_char_code      (i_char_code),
        .i_end_of_message (i_end_of_message),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_unit_on        (o_unit_on),
        .o_last_unit      (o_last_unit)
    );

endmodule
